@@ rtl/core/wfps_pkg.sv @@
// wfps_pkg: shared types and constants for the wall-follow PD steering block.
// Holds payload structs, register indexes, codes and multiply/divide unit widths.
// No dependencies.
package wfps_pkg;

   localparam int MD_MW = 34;
   localparam int MD_XW = 49;
   localparam int MD_DW = 31;
   localparam int MD_NW = 65;
   localparam int MD_PW = 83;
   localparam int MD_RW = 52;
   localparam int FIX_W = 54;

   localparam int CLAMP_RANGE_DEF = 6;

   localparam logic signed [MD_RW-1:0] TERM_LIM = MD_RW'(64'd1 << 50);

   localparam logic [23:0] KP_LED_RST = 24'd524;
   localparam logic [23:0] KD_LED_RST = 24'd131072;
   localparam logic [23:0] KP_ENC_RST = 24'd1966;
   localparam logic [23:0] KD_ENC_RST = 24'd655360;

   localparam logic [2:0] REG_KP_LED    = 3'd0;
   localparam logic [2:0] REG_KD_LED    = 3'd1;
   localparam logic [2:0] REG_KP_ENC    = 3'd2;
   localparam logic [2:0] REG_KD_ENC    = 3'd3;
   localparam logic [2:0] REG_LEFT_THR  = 3'd4;
   localparam logic [2:0] REG_RIGHT_THR = 3'd5;
   localparam logic [2:0] REG_BASE      = 3'd6;
   localparam logic [2:0] REG_ENC_OFS   = 3'd7;

   localparam logic [1:0] MODE_WALL = 2'd0;
   localparam logic [1:0] MODE_HYB  = 2'd2;

   localparam logic [1:0] SRC_LEFT  = 2'd0;
   localparam logic [1:0] SRC_RIGHT = 2'd1;
   localparam logic [1:0] SRC_ENC   = 2'd2;

   typedef struct packed {
      logic [1:0]         steer_mode;
      logic [15:0]        left_front;
      logic [15:0]        right_front;
      logic [15:0]        left_diag;
      logic [15:0]        right_diag;
      logic signed [31:0] left_count;
      logic signed [31:0] right_count;
      logic [23:0]        elapsed_us;
   } req_type;

   typedef struct packed {
      logic [12:0] left_speed;
      logic [12:0] right_speed;
      logic [1:0]  steer_source;
   } rsp_type;

   typedef struct packed {
      logic                     start;
      logic [MD_MW-1:0]         m;
      logic signed [MD_XW-1:0]  x;
      logic [MD_DW-1:0]         d;
   } md_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [MD_RW-1:0]  res;
   } md_rsp_type;

endpackage

@@ rtl/core/wall_follow_pd_steering_top.sv @@
// wall_follow_pd_steering_top: PD steering tick per request beat.
// Depends on wfps_pkg and wfps_muldiv.
//
// One request beat is one control tick and gives one response beat. The block
// works on one tick at a time: req_stall is high from acceptance until the
// response is loaded into the output register, which then waits for the sink
// while the next tick is taken. Every division and gain product runs through
// one shared bit-serial multiply/divide unit; each call runs 65 divide steps,
// 34 multiply steps and 65 divide steps again. A tick makes four plain
// divisions (diagonal snapping and the speed limits) and two PD terms in wall
// or encoder steering, four in hybrid steering.
module wall_follow_pd_steering_top #(
   parameter int CLAMP_RANGE = wfps_pkg::CLAMP_RANGE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wfps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wfps_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int MW = wfps_pkg::MD_MW;
   localparam int XW = wfps_pkg::MD_XW;
   localparam int DW = wfps_pkg::MD_DW;
   localparam int FW = wfps_pkg::FIX_W;
   localparam int LO_MUL = 10 - CLAMP_RANGE;
   localparam int HI_MUL = 10 + CLAMP_RANGE;

   localparam logic [2:0] STEP_LDIV = 3'd0;
   localparam logic [2:0] STEP_RDIV = 3'd1;
   localparam logic [2:0] STEP_LO   = 3'd2;
   localparam logic [2:0] STEP_HI   = 3'd3;
   localparam logic [2:0] STEP_T0   = 3'd4;
   localparam logic [2:0] STEP_T1   = 3'd5;
   localparam logic [2:0] STEP_T2   = 3'd6;
   localparam logic [2:0] STEP_T3   = 3'd7;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_ISSUE  = 7'b0000010,
      ST_WAIT   = 7'b0000100,
      ST_CHOOSE = 7'b0001000,
      ST_ENC1   = 7'b0010000,
      ST_ENC2   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      KIND_WALL,
      KIND_HYB,
      KIND_ENC
   } kind_type;

   function automatic logic [12:0] clamp_spd(input logic signed [39:0] v,
                                             input logic [12:0] lo,
                                             input logic [12:0] hi);
      logic signed [39:0] c;
      c = v;
      if (c < $signed(40'(lo))) begin
         c = 40'(lo);
      end else if (c > $signed(40'(hi))) begin
         c = 40'(hi);
      end
      if (c < 0) begin
         c = '0;
      end
      return c[12:0];
   endfunction

   state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;
   kind_type kind_ff, kind_in;
   wfps_pkg::req_type item_ff, item_in;
   logic [16:0] ld_ff, ld_in;
   logic [16:0] rd_ff, rd_in;
   logic [12:0] lo_ff, lo_in;
   logic [12:0] hi_ff, hi_in;
   logic [1:0]  src_ff, src_in;
   logic signed [17:0] werr_ff, werr_in;
   logic signed [47:0] enca_ff, enca_in;
   logic signed [32:0] encb_ff, encb_in;
   logic signed [47:0] enc_ff, enc_in;
   logic signed [FW-1:0] fix_ff, fix_in;
   logic signed [17:0] prevw_ff, prevw_in;
   logic signed [47:0] preve_ff, preve_in;
   logic [23:0] kp_led_ff, kp_led_in;
   logic [23:0] kd_led_ff, kd_led_in;
   logic [23:0] kp_enc_ff, kp_enc_in;
   logic [23:0] kd_enc_ff, kd_enc_in;
   logic [15:0] lthr_ff, lthr_in;
   logic [15:0] rthr_ff, rthr_in;
   logic [11:0] base_ff, base_in;
   logic signed [31:0] offset_ff, offset_in;
   logic rsp_valid_ff, rsp_valid_in;
   wfps_pkg::rsp_type rsp_data_ff, rsp_data_in;

   wfps_pkg::md_req_type md_req;
   wfps_pkg::md_rsp_type md_rsp;

   logic [25:0] l1000, tl985, tl1015;
   logic [26:0] r1000, tr960, tr1040;
   logic l_band, l_above, r_band, r_above, r_below;
   logic [19:0] t15, snap_xl;
   logic [22:0] t40, t92, snap_xr;
   logic [15:0] q16;
   logic [20:0] ld10, tl7, tl9, rd10, tr7;
   logic [23:0] rd100, tr85;
   logic left_ok, right_ok, wall_mode;
   logic [23:0] e_val;
   logic [DW-1:0] e3, e30, e100;
   logic [MW-1:0] kd1000;
   logic signed [18:0] dw;
   logic signed [48:0] de;
   logic signed [14:0] k_sel;
   logic [2:0] last_step;
   logic signed [FW-1:0] fix_sh, nfix, nfix_sh;
   logic signed [39:0] ls_raw, rs_raw;
   logic can_load;

   wfps_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   always_comb begin
      l1000   = 26'(item_ff.left_diag) * 26'd1000;
      tl985   = 26'(lthr_ff) * 26'd985;
      tl1015  = 26'(lthr_ff) * 26'd1015;
      l_band  = (l1000 > tl985) && (l1000 < tl1015);
      l_above = l1000 > tl1015;
      r1000   = 27'(item_ff.right_diag) * 27'd1000;
      tr960   = 27'(rthr_ff) * 27'd960;
      tr1040  = 27'(rthr_ff) * 27'd1040;
      r_band  = (r1000 > tr960) && (r1000 < tr1040);
      r_above = r1000 > tr1040;
      r_below = r1000 < tr960;
      t15     = 20'(lthr_ff) * 20'd15;
      snap_xl = l_above ? t15 + 20'd999 : t15;
      t40     = 23'(rthr_ff) * 23'd40;
      t92     = 23'(rthr_ff) * 23'd92;
      snap_xr = r_above ? t40 + 23'd999 : (r_below ? t40 : t92);
      q16     = md_rsp.res[15:0];

      ld10    = 21'(ld_ff) * 21'd10;
      tl7     = 21'(lthr_ff) * 21'd7;
      tl9     = 21'(lthr_ff) * 21'd9;
      rd10    = 21'(rd_ff) * 21'd10;
      tr7     = 21'(rthr_ff) * 21'd7;
      rd100   = 24'(rd_ff) * 24'd100;
      tr85    = 24'(rthr_ff) * 24'd85;
      wall_mode = (item_ff.steer_mode == wfps_pkg::MODE_WALL) ||
                  (item_ff.steer_mode == wfps_pkg::MODE_HYB);
      left_ok  = (item_ff.left_front != '0) &&
                 ((item_ff.steer_mode == wfps_pkg::MODE_HYB) ? ld10 > tl9 : ld10 > tl7);
      right_ok = (item_ff.right_front != '0) &&
                 ((item_ff.steer_mode == wfps_pkg::MODE_HYB) ? rd100 > tr85 : rd10 > tr7);

      e_val  = (item_ff.elapsed_us == '0) ? 24'd1 : item_ff.elapsed_us;
      e3     = DW'(e_val) * DW'(3);
      e30    = DW'(e_val) * DW'(30);
      e100   = DW'(e_val) * DW'(100);
      kd1000 = MW'(kd_led_ff) * MW'(1000);
      dw     = 19'(werr_ff) - 19'(prevw_ff);
      de     = 49'(enc_ff) - 49'(preve_ff);
      k_sel  = (kind_ff == KIND_HYB) ? 15'sd10061 : 15'sd10058;
      last_step = (kind_ff == KIND_HYB) ? STEP_T3 : STEP_T1;

      fix_sh  = fix_ff >>> 16;
      nfix    = -fix_ff;
      nfix_sh = nfix >>> 16;
      ls_raw  = $signed(40'(base_ff)) + 40'(fix_sh);
      rs_raw  = $signed(40'(base_ff)) + 40'(nfix_sh);
      can_load = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      md_req.start = state_ff == ST_ISSUE;
      md_req.m     = MW'(1);
      md_req.x     = '0;
      md_req.d     = DW'(1);
      case (step_ff)
         STEP_LDIV: begin
            md_req.x = XW'(snap_xl);
            md_req.d = DW'(1000);
         end
         STEP_RDIV: begin
            md_req.x = XW'(snap_xr);
            md_req.d = (r_above || r_below) ? DW'(1000) : DW'(100);
         end
         STEP_LO: begin
            md_req.x = XW'(17'(base_ff) * 17'(LO_MUL));
            md_req.d = DW'(10);
         end
         STEP_HI: begin
            md_req.x = XW'(17'(base_ff) * 17'(HI_MUL));
            md_req.d = DW'(10);
         end
         STEP_T0: begin
            case (kind_ff)
               KIND_WALL: begin
                  md_req.m = MW'(kp_led_ff);
                  md_req.x = XW'(werr_ff);
                  md_req.d = DW'(1);
               end
               KIND_HYB: begin
                  md_req.m = MW'(kp_led_ff) * MW'(7);
                  md_req.x = XW'(werr_ff);
                  md_req.d = DW'(10);
               end
               default: begin
                  md_req.m = MW'(kp_enc_ff);
                  md_req.x = XW'(enc_ff);
                  md_req.d = DW'(10000);
               end
            endcase
         end
         STEP_T1: begin
            case (kind_ff)
               KIND_WALL: begin
                  md_req.m = kd1000;
                  md_req.x = XW'(dw);
                  md_req.d = e3;
               end
               KIND_HYB: begin
                  md_req.m = MW'(kp_enc_ff) * MW'(3);
                  md_req.x = XW'(enc_ff);
                  md_req.d = DW'(100000);
               end
               default: begin
                  md_req.m = MW'(kd_enc_ff);
                  md_req.x = XW'(de);
                  md_req.d = e30;
               end
            endcase
         end
         STEP_T2: begin
            md_req.m = kd1000;
            md_req.x = XW'(dw);
            md_req.d = e3;
         end
         default: begin
            md_req.m = MW'(kd_enc_ff);
            md_req.x = XW'(de);
            md_req.d = e100;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      kind_in      = kind_ff;
      item_in      = item_ff;
      ld_in        = ld_ff;
      rd_in        = rd_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      src_in       = src_ff;
      werr_in      = werr_ff;
      enca_in      = enca_ff;
      encb_in      = encb_ff;
      enc_in       = enc_ff;
      fix_in       = fix_ff;
      prevw_in     = prevw_ff;
      preve_in     = preve_ff;
      kp_led_in    = kp_led_ff;
      kd_led_in    = kd_led_ff;
      kp_enc_in    = kp_enc_ff;
      kd_enc_in    = kd_enc_ff;
      lthr_in      = lthr_ff;
      rthr_in      = rthr_ff;
      base_in      = base_ff;
      offset_in    = offset_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         case (csr_index)
            wfps_pkg::REG_KP_LED:    kp_led_in = csr_wdata[23:0];
            wfps_pkg::REG_KD_LED:    kd_led_in = csr_wdata[23:0];
            wfps_pkg::REG_KP_ENC:    kp_enc_in = csr_wdata[23:0];
            wfps_pkg::REG_KD_ENC:    kd_enc_in = csr_wdata[23:0];
            wfps_pkg::REG_LEFT_THR:  lthr_in   = csr_wdata[15:0];
            wfps_pkg::REG_RIGHT_THR: rthr_in   = csr_wdata[15:0];
            wfps_pkg::REG_BASE:      base_in   = csr_wdata[11:0];
            wfps_pkg::REG_ENC_OFS:   offset_in = $signed(csr_wdata);
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               step_in  = STEP_LDIV;
               fix_in   = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (md_rsp.done) begin
               case (step_ff)
                  STEP_LDIV: begin
                     ld_in = l_band ? 17'(lthr_ff) :
                             (l_above ? 17'(item_ff.left_diag) - 17'(q16) :
                                        17'(item_ff.left_diag) + 17'(q16));
                  end
                  STEP_RDIV: begin
                     rd_in = r_band ? 17'(rthr_ff) :
                             (r_above ? 17'(item_ff.right_diag) - 17'(q16) :
                             (r_below ? 17'(item_ff.right_diag) + 17'(q16) : 17'(q16)));
                  end
                  STEP_LO: lo_in = md_rsp.res[12:0];
                  STEP_HI: hi_in = md_rsp.res[12:0];
                  default: fix_in = fix_ff + FW'(md_rsp.res);
               endcase
               if (step_ff == STEP_HI) begin
                  state_in = ST_CHOOSE;
               end else if (step_ff == last_step) begin
                  state_in = ST_FINISH;
               end else begin
                  step_in  = step_ff + 3'd1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_CHOOSE: begin
            if (wall_mode && left_ok) begin
               src_in  = wfps_pkg::SRC_LEFT;
               werr_in = $signed(18'(ld_ff)) - $signed(18'(lthr_ff));
            end else if (wall_mode && right_ok) begin
               src_in  = wfps_pkg::SRC_RIGHT;
               werr_in = $signed(18'(rthr_ff)) - $signed(18'(rd_ff));
            end else begin
               src_in  = wfps_pkg::SRC_ENC;
               werr_in = '0;
            end
            if (src_in == wfps_pkg::SRC_ENC) begin
               kind_in = KIND_ENC;
            end else if (item_ff.steer_mode == wfps_pkg::MODE_WALL) begin
               kind_in = KIND_WALL;
            end else begin
               kind_in = KIND_HYB;
            end
            step_in  = STEP_T0;
            state_in = ST_ENC1;
         end
         ST_ENC1: begin
            enca_in  = 48'(item_ff.right_count) * 48'(k_sel);
            encb_in  = 33'(item_ff.left_count) + 33'(offset_ff);
            state_in = ST_ENC2;
         end
         ST_ENC2: begin
            enc_in   = enca_ff - 48'(encb_ff) * 48'sd10000;
            state_in = ST_ISSUE;
         end
         ST_FINISH: begin
            if (can_load) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.left_speed   = clamp_spd(ls_raw, lo_ff, hi_ff);
               rsp_data_in.right_speed  = clamp_spd(rs_raw, lo_ff, hi_ff);
               rsp_data_in.steer_source = src_ff;
               case (kind_ff)
                  KIND_WALL: begin
                     prevw_in  = werr_ff;
                     preve_in  = '0;
                     offset_in = '0;
                  end
                  KIND_HYB: begin
                     prevw_in = werr_ff;
                     preve_in = enc_ff;
                  end
                  default: begin
                     prevw_in = '0;
                     preve_in = enc_ff;
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_LDIV;
         kind_ff      <= KIND_ENC;
         rsp_valid_ff <= 1'b0;
         prevw_ff     <= '0;
         preve_ff     <= '0;
         kp_led_ff    <= wfps_pkg::KP_LED_RST;
         kd_led_ff    <= wfps_pkg::KD_LED_RST;
         kp_enc_ff    <= wfps_pkg::KP_ENC_RST;
         kd_enc_ff    <= wfps_pkg::KD_ENC_RST;
         lthr_ff      <= '0;
         rthr_ff      <= '0;
         base_ff      <= '0;
         offset_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
         prevw_ff     <= prevw_in;
         preve_ff     <= preve_in;
         kp_led_ff    <= kp_led_in;
         kd_led_ff    <= kd_led_in;
         kp_enc_ff    <= kp_enc_in;
         kd_enc_ff    <= kd_enc_in;
         lthr_ff      <= lthr_in;
         rthr_ff      <= rthr_in;
         base_ff      <= base_in;
         offset_ff    <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      ld_ff       <= ld_in;
      rd_ff       <= rd_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      src_ff      <= src_in;
      werr_ff     <= werr_in;
      enca_ff     <= enca_in;
      encb_ff     <= encb_in;
      enc_ff      <= enc_in;
      fix_ff      <= fix_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/core/wfps_muldiv.sv @@
// wfps_muldiv: bit-serial floor(m*x/d) with saturation to +/-2^50.
// Divides x by d, multiplies quotient and remainder by m, divides again.
// Depends on wfps_pkg.
module wfps_muldiv (
   input  logic                 clock,
   input  logic                 reset,
   input  wfps_pkg::md_req_type md_req,
   output wfps_pkg::md_rsp_type md_rsp
);

   localparam int MW = wfps_pkg::MD_MW;
   localparam int XW = wfps_pkg::MD_XW;
   localparam int DW = wfps_pkg::MD_DW;
   localparam int NW = wfps_pkg::MD_NW;
   localparam int PW = wfps_pkg::MD_PW;
   localparam int RW = wfps_pkg::MD_RW;
   localparam int CW = $clog2(NW);

   typedef enum logic [5:0] {
      MD_IDLE = 6'b000001,
      MD_DIV1 = 6'b000010,
      MD_FIX  = 6'b000100,
      MD_MUL  = 6'b001000,
      MD_DIV2 = 6'b010000,
      MD_OUT  = 6'b100000
   } md_state_type;

   md_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] d_ff, d_in;
   logic [MW-1:0] m_ff, m_in;
   logic          xneg_ff, xneg_in;
   logic          qneg_ff, qneg_in;
   logic [PW-1:0] qsh_ff, qsh_in;
   logic [NW-1:0] rsh_ff, rsh_in;
   logic [PW-1:0] accp_ff, accp_in;
   logic [NW-1:0] accr_ff, accr_in;

   logic [DW:0]   rem_sh;
   logic          step_ge;
   logic [DW:0]   rem_sub;
   logic [XW-1:0] xraw;
   logic [XW-1:0] xmag;
   logic          rnz;
   logic [XW-1:0] qmag;
   logic [DW-1:0] rfix;
   logic [PW-1:0] accp_add;
   logic [NW-1:0] accr_add;
   logic          sat;
   logic signed [RW-1:0] pmag;
   logic signed [RW-1:0] fq;
   logic signed [RW-1:0] sum;
   logic signed [RW-1:0] res;

   always_comb begin
      rem_sh   = {rem_ff, num_ff[NW-1]};
      step_ge  = rem_sh >= {1'b0, d_ff};
      rem_sub  = step_ge ? rem_sh - {1'b0, d_ff} : rem_sh;
      xraw     = md_req.x;
      xmag     = xraw[XW-1] ? ~xraw + XW'(1) : xraw;
      rnz      = rem_ff != '0;
      qmag     = num_ff[XW-1:0] + XW'(xneg_ff && rnz);
      rfix     = (xneg_ff && rnz) ? d_ff - rem_ff : rem_ff;
      accp_add = accp_ff + (m_ff[0] ? qsh_ff : '0);
      accr_add = accr_ff + (m_ff[0] ? rsh_ff : '0);
      sat      = accp_ff > PW'(wfps_pkg::TERM_LIM);
      pmag     = $signed(accp_ff[RW-1:0]);
      fq       = $signed(RW'(num_ff[MW-1:0]));
      sum      = qneg_ff ? fq - pmag : pmag + fq;
      if (sat) begin
         res = qneg_ff ? -wfps_pkg::TERM_LIM : wfps_pkg::TERM_LIM;
      end else if (sum > wfps_pkg::TERM_LIM) begin
         res = wfps_pkg::TERM_LIM;
      end else if (sum < -wfps_pkg::TERM_LIM) begin
         res = -wfps_pkg::TERM_LIM;
      end else begin
         res = sum;
      end
   end

   assign md_rsp.done = state_ff == MD_OUT;
   assign md_rsp.res  = res;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      d_in     = d_ff;
      m_in     = m_ff;
      xneg_in  = xneg_ff;
      qneg_in  = qneg_ff;
      qsh_in   = qsh_ff;
      rsh_in   = rsh_ff;
      accp_in  = accp_ff;
      accr_in  = accr_ff;
      case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               d_in     = md_req.d;
               m_in     = md_req.m;
               xneg_in  = xraw[XW-1];
               num_in   = NW'(xmag);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = MD_DIV1;
            end
         end
         MD_DIV1: begin
            num_in = {num_ff[NW-2:0], step_ge};
            rem_in = rem_sub[DW-1:0];
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NW-1)) begin
               cnt_in   = '0;
               state_in = MD_FIX;
            end
         end
         MD_FIX: begin
            qneg_in  = xneg_ff && (qmag != '0);
            qsh_in   = PW'(qmag);
            rsh_in   = NW'(rfix);
            accp_in  = '0;
            accr_in  = '0;
            cnt_in   = '0;
            state_in = MD_MUL;
         end
         MD_MUL: begin
            accp_in = accp_add;
            accr_in = accr_add;
            qsh_in  = qsh_ff << 1;
            rsh_in  = rsh_ff << 1;
            m_in    = m_ff >> 1;
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(MW-1)) begin
               num_in   = accr_add;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = MD_DIV2;
            end
         end
         MD_DIV2: begin
            num_in = {num_ff[NW-2:0], step_ge};
            rem_in = rem_sub[DW-1:0];
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NW-1)) begin
               cnt_in   = '0;
               state_in = MD_OUT;
            end
         end
         MD_OUT: begin
            state_in = MD_IDLE;
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      d_ff    <= d_in;
      m_ff    <= m_in;
      xneg_ff <= xneg_in;
      qneg_ff <= qneg_in;
      qsh_ff  <= qsh_in;
      rsh_ff  <= rsh_in;
      accp_ff <= accp_in;
      accr_ff <= accr_in;
   end

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for wall_follow_pd_steering_top.
// Drives random and directed steering ticks, predicts each response from its own
// fixed-point model of the PD law, and compares; depends on wfps_pkg and the RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_ENC   = 2'd1;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam longint TERM_MAX = 64'sd1 << 50;
   localparam int STALL_LIMIT = 40000;
   localparam int REQ_W = $bits(wfps_pkg::req_type);

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   wfps_pkg::req_type   req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   wfps_pkg::rsp_type   rsp_data;
   logic                csr_we = 1'b0;
   logic [2:0]          csr_index = '0;
   logic [31:0]         csr_wdata = '0;

   wfps_pkg::rsp_type speed_queue[$];
   int      errors = 0;
   int      quiet_cycles = 0;
   bit      jitter_on = 1'b1;

   longint kp_led, kd_led, kp_enc, kd_enc, thr_left, thr_right, base_spd, enc_ofs;
   longint last_wall_err, last_enc_err;

   wall_follow_pd_steering_top DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint scaled_term(longint m, longint x, longint d);
      longint q, r, lim, v;
      q = x / d;
      r = x % d;
      if (r < 0) begin
         r += d;
         q -= 1;
      end
      if (m == 0) return 0;
      lim = TERM_MAX / m;
      if (q > lim) return TERM_MAX;
      if (q < -lim) return -TERM_MAX;
      v = m * q + (m * r) / d;
      if (v > TERM_MAX) v = TERM_MAX;
      if (v < -TERM_MAX) v = -TERM_MAX;
      return v;
   endfunction

   function automatic longint wheel_speed(longint v, longint lo, longint hi);
      longint q;
      q = v / 65536;
      if (v % 65536 < 0) q -= 1;
      if (q < lo) q = lo;
      else if (q > hi) q = hi;
      if (q < 0) q = 0;
      return q;
   endfunction

   function automatic wfps_pkg::rsp_type steer_tick(wfps_pkg::req_type t);
      longint l, r, tl, tr, lc, rc, e, werr, enc, fix, lo, hi;
      logic [1:0] src;
      wfps_pkg::rsp_type o;
      tl = thr_left;
      tr = thr_right;
      l = longint'(t.left_diag);
      r = longint'(t.right_diag);
      if (1000 * l > 985 * tl && 1000 * l < 1015 * tl) l = tl;
      else if (1000 * l > 1015 * tl) l = l - (15 * tl + 999) / 1000;
      else l = l + (15 * tl) / 1000;
      if (1000 * r > 960 * tr && 1000 * r < 1040 * tr) r = tr;
      else if (1000 * r > 1040 * tr) r = r - (40 * tr + 999) / 1000;
      else if (1000 * r < 960 * tr) r = r + (40 * tr) / 1000;
      else r = (92 * tr) / 100;
      lc = longint'(t.left_count);
      rc = longint'(t.right_count);
      e = longint'(t.elapsed_us);
      if (e == 0) e = 1;
      werr = 0;
      src = wfps_pkg::SRC_ENC;
      if (t.steer_mode == wfps_pkg::MODE_WALL) begin
         if (t.left_front > 0 && 10 * l > 7 * tl) begin
            src = wfps_pkg::SRC_LEFT;
            werr = l - tl;
         end else if (t.right_front > 0 && 10 * r > 7 * tr) begin
            src = wfps_pkg::SRC_RIGHT;
            werr = tr - r;
         end
      end else if (t.steer_mode == wfps_pkg::MODE_HYB) begin
         if (t.left_front > 0 && 10 * l > 9 * tl) begin
            src = wfps_pkg::SRC_LEFT;
            werr = l - tl;
         end else if (t.right_front > 0 && 100 * r > 85 * tr) begin
            src = wfps_pkg::SRC_RIGHT;
            werr = tr - r;
         end
      end
      if (src != wfps_pkg::SRC_ENC && t.steer_mode == wfps_pkg::MODE_WALL) begin
         fix = scaled_term(kp_led, werr, 1)
             + scaled_term(kd_led * 1000, werr - last_wall_err, 3 * e);
         enc_ofs = 0;
         last_wall_err = werr;
         last_enc_err = 0;
      end else if (src != wfps_pkg::SRC_ENC) begin
         enc = 10061 * rc - 10000 * lc - 10000 * enc_ofs;
         fix = scaled_term(7 * kp_led, werr, 10)
             + scaled_term(3 * kp_enc, enc, 100000)
             + scaled_term(kd_led * 1000, werr - last_wall_err, 3 * e)
             + scaled_term(kd_enc, enc - last_enc_err, 100 * e);
         last_wall_err = werr;
         last_enc_err = enc;
      end else begin
         enc = 10058 * rc - 10000 * lc - 10000 * enc_ofs;
         fix = scaled_term(kp_enc, enc, 10000)
             + scaled_term(kd_enc, enc - last_enc_err, 30 * e);
         last_wall_err = 0;
         last_enc_err = enc;
      end
      lo = (base_spd * (10 - wfps_pkg::CLAMP_RANGE_DEF)) / 10;
      hi = (base_spd * (10 + wfps_pkg::CLAMP_RANGE_DEF)) / 10;
      o.left_speed = 13'(wheel_speed(base_spd * 65536 + fix, lo, hi));
      o.right_speed = 13'(wheel_speed(base_spd * 65536 - fix, lo, hi));
      o.steer_source = src;
      return o;
   endfunction

   task automatic send_tick(wfps_pkg::req_type t);
      if (jitter_on) begin
         while ($urandom_range(99) < 34) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      req_valid = 1'b1;
      req_data = t;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      speed_queue.push_back(steer_tick(t));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (speed_queue.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         wfps_pkg::REG_KP_LED:    kp_led = longint'(val[23:0]);
         wfps_pkg::REG_KD_LED:    kd_led = longint'(val[23:0]);
         wfps_pkg::REG_KP_ENC:    kp_enc = longint'(val[23:0]);
         wfps_pkg::REG_KD_ENC:    kd_enc = longint'(val[23:0]);
         wfps_pkg::REG_LEFT_THR:  thr_left = longint'(val[15:0]);
         wfps_pkg::REG_RIGHT_THR: thr_right = longint'(val[15:0]);
         wfps_pkg::REG_BASE:      base_spd = longint'(val[11:0]);
         wfps_pkg::REG_ENC_OFS:   enc_ofs = longint'($signed(val));
         default: ;
      endcase
   endtask

   task automatic write_all(logic [23:0] kpl, logic [23:0] kdl, logic [23:0] kpe,
                            logic [23:0] kde, logic [15:0] tl, logic [15:0] tr,
                            logic [11:0] b, logic [31:0] ofs);
      write_reg(wfps_pkg::REG_KP_LED, 32'(kpl));
      write_reg(wfps_pkg::REG_KD_LED, 32'(kdl));
      write_reg(wfps_pkg::REG_KP_ENC, 32'(kpe));
      write_reg(wfps_pkg::REG_KD_ENC, 32'(kde));
      write_reg(wfps_pkg::REG_LEFT_THR, 32'(tl));
      write_reg(wfps_pkg::REG_RIGHT_THR, 32'(tr));
      write_reg(wfps_pkg::REG_BASE, 32'(b));
      write_reg(wfps_pkg::REG_ENC_OFS, ofs);
   endtask

   function automatic logic [15:0] near_level(longint thr);
      longint v;
      v = thr + longint'($urandom_range(32'(2 * (thr / 8) + 4))) - thr / 8 - 2;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return 16'(v);
   endfunction

   function automatic wfps_pkg::req_type random_tick();
      wfps_pkg::req_type t;
      t = wfps_pkg::req_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom}));
      if ($urandom_range(99) < 80) begin
         t.steer_mode = 2'($urandom_range(2));
         if ($urandom_range(9) != 0) t.left_front = 16'($urandom_range(65535, 1));
         if ($urandom_range(9) != 0) t.right_front = 16'($urandom_range(65535, 1));
         t.left_diag = near_level(thr_left);
         t.right_diag = near_level(thr_right);
         if ($urandom_range(3) != 0) begin
            t.left_count = $signed(32'($urandom_range(2000))) - 1000;
            t.right_count = t.left_count + $signed(32'($urandom_range(40))) - 20;
         end
         if ($urandom_range(3) != 0) t.elapsed_us = 24'($urandom_range(3000));
      end
      return t;
   endfunction

   task automatic test_reset_values();
      wfps_pkg::req_type t;
      for (int i = 0; i < 6; i++) begin
         t = random_tick();
         send_tick(t);
      end
      drain();
   endtask

   task automatic test_directed();
      wfps_pkg::req_type t;
      write_all(24'd524, 24'd131072, 24'd1966, 24'd655360, 16'd1000, 16'd1000,
                12'd2000, 32'd0);
      t = '0;
      t.left_front = 16'd5;
      t.right_front = 16'd5;
      t.steer_mode = wfps_pkg::MODE_WALL;
      t.left_diag = 16'd985;  send_tick(t);
      t.left_diag = 16'd1015; send_tick(t);
      t.left_diag = 16'd1200; send_tick(t);
      t.left_diag = 16'd600;  send_tick(t);
      t.left_front = 16'd0;
      t.right_diag = 16'd960;  send_tick(t);
      t.right_diag = 16'd1040; send_tick(t);
      t.right_diag = 16'd1300; send_tick(t);
      t.right_diag = 16'd800;  send_tick(t);
      t.right_front = 16'd0;   send_tick(t);
      t.right_front = 16'hFFFF;
      t.left_front = 16'hFFFF;
      t.left_diag = 16'hFFFF;
      t.right_diag = 16'hFFFF;
      t.elapsed_us = 24'hFFFFFF;
      send_tick(t);
      t.steer_mode = wfps_pkg::MODE_HYB;
      t.left_diag = 16'd950;
      t.right_diag = 16'd900;
      t.left_count = 32'sh7FFFFFFF;
      t.right_count = -32'sh80000000;
      send_tick(t);
      t.left_diag = 16'd0;
      t.elapsed_us = 24'd0;
      send_tick(t);
      t.steer_mode = MODE_ENC;
      send_tick(t);
      t.left_count = -32'sh80000000;
      t.right_count = 32'sh7FFFFFFF;
      send_tick(t);
      t.steer_mode = MODE_SPARE;
      t.left_count = 32'sd100;
      t.right_count = 32'sd250;
      send_tick(t);
      drain();
      write_reg(wfps_pkg::REG_ENC_OFS, 32'h8000_0000);
      send_tick(t);
      t.steer_mode = wfps_pkg::MODE_WALL;
      t.left_diag = 16'd1000;
      send_tick(t);
      t.steer_mode = MODE_ENC;
      send_tick(t);
      drain();
   endtask

   task automatic run_random(int count);
      wfps_pkg::req_type t;
      for (int i = 0; i < count; i++) begin
         t = random_tick();
         send_tick(t);
         if (i == count / 2) drain();
      end
      drain();
   endtask

   task automatic test_random_settings();
      write_all(24'd524, 24'd131072, 24'd1966, 24'd655360, 16'd2000, 16'd1800,
                12'd1500, 32'd40);
      run_random(250);
      write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
                12'hFFF, 32'h7FFF_FFFF);
      run_random(150);
      write_all(24'd0, 24'd0, 24'd0, 24'd0, 16'd0, 16'd0, 12'd0, 32'h8000_0000);
      run_random(100);
      write_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                16'($urandom_range(500, 60000)), 16'($urandom_range(500, 60000)),
                12'($urandom), $urandom);
      run_random(250);
   endtask

   task automatic test_no_idle();
      jitter_on = 1'b0;
      write_all(24'd3000, 24'd40000, 24'd2500, 24'd300000, 16'd1200, 16'd1300,
                12'd4095, 32'hFFFF_FFF0);
      run_random(250);
      jitter_on = 1'b1;
      write_all(24'd800, 24'd200000, 24'd900, 24'd1000000, 16'd300, 16'd65535,
                12'd1, 32'd0);
      run_random(230);
   endtask

   always @(negedge clock) begin
      rsp_stall <= jitter_on && ($urandom_range(99) < 34);
   end

   always @(posedge clock) begin
      wfps_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (speed_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual %p", $time, rsp_data);
         end else begin
            want = speed_queue.pop_front();
            if (rsp_data.left_speed !== want.left_speed) begin
               errors++;
               $display("%0t: left_speed expected %0d actual %0d", $time,
                        want.left_speed, rsp_data.left_speed);
            end
            if (rsp_data.right_speed !== want.right_speed) begin
               errors++;
               $display("%0t: right_speed expected %0d actual %0d", $time,
                        want.right_speed, rsp_data.right_speed);
            end
            if (rsp_data.steer_source !== want.steer_source) begin
               errors++;
               $display("%0t: steer_source expected %0d actual %0d", $time,
                        want.steer_source, rsp_data.steer_source);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL wall_follow_pd_steering_top");
         $finish;
      end
   end

   initial begin
      kp_led = longint'(wfps_pkg::KP_LED_RST);
      kd_led = longint'(wfps_pkg::KD_LED_RST);
      kp_enc = longint'(wfps_pkg::KP_ENC_RST);
      kd_enc = longint'(wfps_pkg::KD_ENC_RST);
      thr_left = 0;
      thr_right = 0;
      base_spd = 0;
      enc_ofs = 0;
      last_wall_err = 0;
      last_enc_err = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;
      test_reset_values();
      test_directed();
      test_random_settings();
      test_no_idle();
      if (errors == 0)
         $display("PASS wall_follow_pd_steering_top");
      else
         $display("FAIL wall_follow_pd_steering_top");
      $finish;
   end
endmodule
